// File: hdl/ihuc_pkg.sv
// Shared types, constants and functions of the image header UID checker.
`default_nettype none
package ihuc_pkg;

  localparam int HEADER_WORDS = 31;
  localparam int POS_W        = $clog2(HEADER_WORDS);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int MARK_W       = 10;

  localparam logic [POS_W-1:0] POS_UID_LAST   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_UID_SUM    = POS_W'(3);
  localparam logic [POS_W-1:0] POS_SIGNATURE  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_DATA_SUM   = POS_W'(7);
  localparam logic [POS_W-1:0] POS_FLAGS      = POS_W'(11);
  localparam logic [POS_W-1:0] POS_DLL_COUNT  = POS_W'(21);
  localparam logic [POS_W-1:0] POS_EXPORT_CNT = POS_W'(23);
  localparam logic [POS_W-1:0] POS_DATA_RELOC = POS_W'(29);
  localparam logic [POS_W-1:0] POS_LAST       = POS_W'(HEADER_WORDS - 1);

  localparam logic [31:0] SIGNATURE_WORD = 32'h434F_5045;
  localparam logic [15:0] CRC_POLY       = 16'h1021;

  typedef enum logic [3:0] {
    STATUS_OK          = 4'd0,
    STATUS_FIXED_ADDR  = 4'd1,
    STATUS_HDR_FORMAT  = 4'd2,
    STATUS_ENTRY_TYPE  = 4'd3,
    STATUS_IMP_FORMAT  = 4'd4,
    STATUS_ABI         = 4'd5,
    STATUS_DATA_RELOC  = 4'd6,
    STATUS_SIGNATURE   = 4'd7,
    STATUS_UID_SUM     = 4'd8,
    STATUS_DLL_ZERO    = 4'd9,
    STATUS_EXPORT_CNT  = 4'd10
  } status_t;

  // mark bit index for a status code
  localparam int MARK_FIXED  = 0;
  localparam int MARK_HDRFMT = 1;
  localparam int MARK_ENTRY  = 2;
  localparam int MARK_IMPFMT = 3;
  localparam int MARK_ABI    = 4;
  localparam int MARK_DRELOC = 5;
  localparam int MARK_SIG    = 6;
  localparam int MARK_UIDSUM = 7;
  localparam int MARK_DLL    = 8;
  localparam int MARK_EXPORT = 9;

  typedef enum logic [3:0] {
    KIND_NONE,
    KIND_UID,
    KIND_UID_SUM,
    KIND_SIGNATURE,
    KIND_DATA_SUM,
    KIND_FLAGS,
    KIND_DLL_COUNT,
    KIND_EXPORT_CNT,
    KIND_DATA_RELOC
  } kind_t;

  typedef struct packed {
    logic [31:0] word;
    kind_t       kind;
    logic        start;
    logic        last;
  } request_t;

  // 16 data bits MSB first through CRC-16-CCITT; linear, so it flattens to an xor tree
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [15:0] data);
    logic [15:0] r;
    r = crc ^ data;
    for (int i = 0; i < 16; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic status_t first_failure(input logic [MARK_W-1:0] marks);
    status_t s;
    s = STATUS_OK;
    for (int k = MARK_W - 1; k >= 0; k--) begin
      if (marks[k]) begin
        s = status_t'(4'(k + 1));
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: hdl/ihuc_front.sv
// Front end: word position counter and per-word classification.
`default_nettype none
module ihuc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [31:0]       header_word,
  input  wire logic              first,
  input  wire logic              q_full,
  output logic                   push,
  output ihuc_pkg::request_t     req
);

  logic [ihuc_pkg::POS_W-1:0] word_position;
  logic [ihuc_pkg::POS_W-1:0] word_position_next;
  logic [ihuc_pkg::POS_W-1:0] pos;
  ihuc_pkg::kind_t            kind;

  assign push = in_valid && !q_full;
  assign pos  = first ? '0 : word_position;

  always_comb begin
    if (pos <= ihuc_pkg::POS_UID_LAST) begin
      kind = ihuc_pkg::KIND_UID;
    end else begin
      case (pos)
        ihuc_pkg::POS_UID_SUM:    kind = ihuc_pkg::KIND_UID_SUM;
        ihuc_pkg::POS_SIGNATURE:  kind = ihuc_pkg::KIND_SIGNATURE;
        ihuc_pkg::POS_DATA_SUM:   kind = ihuc_pkg::KIND_DATA_SUM;
        ihuc_pkg::POS_FLAGS:      kind = ihuc_pkg::KIND_FLAGS;
        ihuc_pkg::POS_DLL_COUNT:  kind = ihuc_pkg::KIND_DLL_COUNT;
        ihuc_pkg::POS_EXPORT_CNT: kind = ihuc_pkg::KIND_EXPORT_CNT;
        ihuc_pkg::POS_DATA_RELOC: kind = ihuc_pkg::KIND_DATA_RELOC;
        default:                  kind = ihuc_pkg::KIND_NONE;
      endcase
    end
  end

  always_comb begin
    req.word  = header_word;
    req.kind  = kind;
    req.start = (pos == '0);
    req.last  = (pos >= ihuc_pkg::POS_LAST);
    word_position_next = req.last ? '0 : pos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
    end else if (push) begin
      word_position <= word_position_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ihuc_queue.sv
// Two-entry request queue between front and back end.
`default_nettype none
module ihuc_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ihuc_pkg::request_t push_req,
  input  wire logic               pop,
  output logic                    full,
  output logic                    not_empty,
  output ihuc_pkg::request_t      head
);

  ihuc_pkg::request_t               entries [ihuc_pkg::QUEUE_DEPTH];
  logic [ihuc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [ihuc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [ihuc_pkg::QCNT_W-1:0]      count;

  assign full      = (count == ihuc_pkg::QCNT_W'(ihuc_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ihuc_pkg::QPTR_W'(ihuc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ihuc_pkg::QPTR_W'(ihuc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= ihuc_pkg::QCNT_W'(ihuc_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: hdl/ihuc_back.sv
// Back end: UID CRCs, header checks and the registered result.
`default_nettype none
module ihuc_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_not_empty,
  input  wire ihuc_pkg::request_t req,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              status,
  output logic [31:0]             computed_uid_checksum
);

  logic [15:0]                even_crc;
  logic [15:0]                odd_crc;
  logic                       data_checksum_nonzero;
  logic [ihuc_pkg::MARK_W-1:0] failure_marks;

  logic [15:0]                even_base, odd_base, even_crc_next, odd_crc_next;
  logic                       dsum_base, data_checksum_nonzero_next;
  logic [ihuc_pkg::MARK_W-1:0] marks_base, failure_marks_next;
  logic [31:0]                w;

  assign pop = q_not_empty && (!out_valid || !out_stall);
  assign w   = req.word;

  always_comb begin
    even_base  = req.start ? '0 : even_crc;
    odd_base   = req.start ? '0 : odd_crc;
    dsum_base  = req.start ? 1'b0 : data_checksum_nonzero;
    marks_base = req.start ? '0 : failure_marks;
    even_crc_next              = even_base;
    odd_crc_next               = odd_base;
    data_checksum_nonzero_next = dsum_base;
    failure_marks_next         = marks_base;
    case (req.kind)
      ihuc_pkg::KIND_UID: begin
        even_crc_next = ihuc_pkg::crc16_update(even_base, {w[7:0], w[23:16]});
        odd_crc_next  = ihuc_pkg::crc16_update(odd_base, {w[15:8], w[31:24]});
      end
      ihuc_pkg::KIND_UID_SUM: begin
        if (w != {odd_base, even_base}) begin
          failure_marks_next[ihuc_pkg::MARK_UIDSUM] = 1'b1;
        end
      end
      ihuc_pkg::KIND_SIGNATURE: begin
        if (w != ihuc_pkg::SIGNATURE_WORD) begin
          failure_marks_next[ihuc_pkg::MARK_SIG] = 1'b1;
        end
      end
      ihuc_pkg::KIND_DATA_SUM: begin
        data_checksum_nonzero_next = (w != '0);
      end
      ihuc_pkg::KIND_FLAGS: begin
        if (w[2]) begin
          failure_marks_next[ihuc_pkg::MARK_FIXED] = 1'b1;
        end
        if ((w[27:24] != '0) && dsum_base) begin
          failure_marks_next[ihuc_pkg::MARK_HDRFMT] = 1'b1;
        end
        if (w[7:5] != '0) begin
          failure_marks_next[ihuc_pkg::MARK_ENTRY] = 1'b1;
        end
        if (w[31:28] != '0) begin
          failure_marks_next[ihuc_pkg::MARK_IMPFMT] = 1'b1;
        end
        if (w[4:3] != '0) begin
          failure_marks_next[ihuc_pkg::MARK_ABI] = 1'b1;
        end
      end
      ihuc_pkg::KIND_DLL_COUNT: begin
        if (w == '0) begin
          failure_marks_next[ihuc_pkg::MARK_DLL] = 1'b1;
        end
      end
      ihuc_pkg::KIND_EXPORT_CNT: begin
        if (w != 32'd1) begin
          failure_marks_next[ihuc_pkg::MARK_EXPORT] = 1'b1;
        end
      end
      ihuc_pkg::KIND_DATA_RELOC: begin
        if (w != '0) begin
          failure_marks_next[ihuc_pkg::MARK_DRELOC] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      even_crc              <= '0;
      odd_crc               <= '0;
      data_checksum_nonzero <= 1'b0;
      failure_marks         <= '0;
    end else if (pop) begin
      even_crc              <= even_crc_next;
      odd_crc               <= odd_crc_next;
      data_checksum_nonzero <= data_checksum_nonzero_next;
      failure_marks         <= failure_marks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && req.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && req.last) begin
      status                <= ihuc_pkg::first_failure(failure_marks_next);
      computed_uid_checksum <= {odd_crc_next, even_crc_next};
    end
  end

  assert property (@(posedge clk) disable iff (rst) (pop && req.last) |=> out_valid)
    else $error("header end without result");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !(pop && req.last)) |=> !out_valid)
    else $error("result repeated");
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_stall) |-> !pop)
    else $error("request consumed while result held");

endmodule
`default_nettype wire

// File: hdl/image_header_uid_checker.sv
// Top level of the image header UID checker.
// Takes one 32-bit header word per cycle, with no bubbles unless a held result stalls the
// back end; a front end counts word positions and classifies each word, a two-entry queue
// decouples it from the back end, which updates the even/odd byte CRC-16s and the failure
// marks for each word it takes. One result (first failure status and computed UID sum)
// is registered when the back end takes the last of the 31 words, only while the output
// register is free, and is held there until taken; first=1 restarts a header at any word.
`default_nettype none
module image_header_uid_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] header_word,
  input  wire logic        first,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       status,
  output logic [31:0]      computed_uid_checksum
);

  ihuc_pkg::request_t front_req;
  ihuc_pkg::request_t head_req;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_not_empty;

  assign in_stall = q_full;

  ihuc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .header_word (header_word),
    .first       (first),
    .q_full      (q_full),
    .push        (push),
    .req         (front_req)
  );

  ihuc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_req  (front_req),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_req)
  );

  ihuc_back u_back (
    .clk                   (clk),
    .rst                   (rst),
    .q_not_empty           (q_not_empty),
    .req                   (head_req),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .status                (status),
    .computed_uid_checksum (computed_uid_checksum)
  );

endmodule
`default_nettype wire
